/* rtl/core/irfe_pkg.sv */
// ----------------------------------------------------------------------------
// irfe_pkg
// shared types, constants and tables of the ir remote frame encoder
// ----------------------------------------------------------------------------
package irfe_pkg;

  // field widths
  localparam int FREQ_W  = 17;
  localparam int DUR_W   = 14;
  localparam int RECIP_W = 27;
  localparam int PROD_W  = FREQ_W + RECIP_W;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 32;
  localparam int CFG_A_W = 1;

  // register indexes
  localparam logic [CFG_A_W-1:0] CFG_CARRIER_FREQ = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_PROTOCOL     = 1'b1;

  localparam logic [FREQ_W-1:0] CARRIER_FREQ_RST = 17'd36000;

  typedef enum logic [1:0] {
    PROTO_RC5  = 2'd0,
    PROTO_NEC  = 2'd1,
    PROTO_SAM  = 2'd2,
    PROTO_NONE = 2'd3
  } proto_t;

  // rc5 level slots: one mark slot for the start bit, then two per coded bit
  localparam int RC5_SLOTS = 27;
  localparam logic [4:0] RC5_LAST_SLOT = 5'd26;
  localparam logic [7:0] RC5_TOGGLE_PRESS = 8'd2;

  // pulse-distance frames: header pair, 32 data pairs, stop pair
  localparam logic [5:0] PD_LAST_PAIR = 6'd33;

  // durations are carrier_freq * scale / 1e6, scale in microseconds
  localparam int DUR_COUNT = 7;
  localparam logic [2:0] DUR_HALF     = 3'd0;
  localparam logic [2:0] DUR_RC5_GAP  = 3'd1;
  localparam logic [2:0] DUR_NEC_HDR  = 3'd2;
  localparam logic [2:0] DUR_PAUSE    = 3'd3;
  localparam logic [2:0] DUR_SHORT    = 3'd4;
  localparam logic [2:0] DUR_LONG     = 3'd5;
  localparam logic [2:0] DUR_PD_GAP   = 3'd6;

  localparam longint unsigned US_PER_S = 64'd1000000;

  // freq * ceil(scale * 2^sh / 1e6) >> sh gives the truncated quotient exactly
  // for every 17-bit freq; each shift is the smallest that keeps the rounding
  // error below the spacing of the quotient's fractional part
  localparam logic [5:0] SH_HALF    = 6'd37;
  localparam logic [5:0] SH_RC5_GAP = 6'd27;
  localparam logic [5:0] SH_NEC_HDR = 6'd27;
  localparam logic [5:0] SH_PAUSE   = 6'd28;
  localparam logic [5:0] SH_SHORT   = 6'd31;
  localparam logic [5:0] SH_LONG    = 6'd31;
  localparam logic [5:0] SH_PD_GAP  = 6'd24;

  localparam logic [RECIP_W-1:0] RECIP_HALF =
    RECIP_W'(((64'd889 << SH_HALF) + US_PER_S - 64'd1) / US_PER_S);
  localparam logic [RECIP_W-1:0] RECIP_RC5_GAP =
    RECIP_W'(((64'd89000 << SH_RC5_GAP) + US_PER_S - 64'd1) / US_PER_S);
  localparam logic [RECIP_W-1:0] RECIP_NEC_HDR =
    RECIP_W'(((64'd9000 << SH_NEC_HDR) + US_PER_S - 64'd1) / US_PER_S);
  localparam logic [RECIP_W-1:0] RECIP_PAUSE =
    RECIP_W'(((64'd4500 << SH_PAUSE) + US_PER_S - 64'd1) / US_PER_S);
  localparam logic [RECIP_W-1:0] RECIP_SHORT =
    RECIP_W'(((64'd560 << SH_SHORT) + US_PER_S - 64'd1) / US_PER_S);
  localparam logic [RECIP_W-1:0] RECIP_LONG =
    RECIP_W'(((64'd1680 << SH_LONG) + US_PER_S - 64'd1) / US_PER_S);
  localparam logic [RECIP_W-1:0] RECIP_PD_GAP =
    RECIP_W'(((64'd110000 << SH_PD_GAP) + US_PER_S - 64'd1) / US_PER_S);

  function automatic logic [RECIP_W-1:0] dur_recip(input logic [2:0] idx);
    logic [RECIP_W-1:0] r;
    case (idx)
      DUR_HALF:    r = RECIP_HALF;
      DUR_RC5_GAP: r = RECIP_RC5_GAP;
      DUR_NEC_HDR: r = RECIP_NEC_HDR;
      DUR_PAUSE:   r = RECIP_PAUSE;
      DUR_SHORT:   r = RECIP_SHORT;
      DUR_LONG:    r = RECIP_LONG;
      DUR_PD_GAP:  r = RECIP_PD_GAP;
      default:     r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] dur_shift(input logic [2:0] idx);
    logic [5:0] sh;
    case (idx)
      DUR_HALF:    sh = SH_HALF;
      DUR_RC5_GAP: sh = SH_RC5_GAP;
      DUR_NEC_HDR: sh = SH_NEC_HDR;
      DUR_PAUSE:   sh = SH_PAUSE;
      DUR_SHORT:   sh = SH_SHORT;
      DUR_LONG:    sh = SH_LONG;
      DUR_PD_GAP:  sh = SH_PD_GAP;
      default:     sh = '0;
    endcase
    return sh;
  endfunction

  typedef struct packed {
    logic [DUR_W-1:0] half;
    logic [DUR_W-1:0] rc5_gap;
    logic [DUR_W-1:0] nec_hdr;
    logic [DUR_W-1:0] pause;
    logic [DUR_W-1:0] short_d;
    logic [DUR_W-1:0] long_d;
    logic [DUR_W-1:0] pd_gap;
  } dur_t;

  // one queued frame
  typedef struct packed {
    proto_t                 proto;
    logic [RC5_SLOTS-1:0]   lvl;
    logic [31:0]            bits;
  } desc_t;

  typedef enum logic [1:0] {
    DS_IDLE  = 2'd0,
    DS_MUL   = 2'd1,
    DS_SHIFT = 2'd2
  } dur_state_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_RC5  = 2'd1,
    BK_PD   = 2'd2
  } back_state_t;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

endpackage

/* rtl/core/irfe_dur.sv */
// ----------------------------------------------------------------------------
// irfe_dur
// works out the carrier-cycle durations, one multiply and one shift each
// ----------------------------------------------------------------------------
module irfe_dur (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic [irfe_pkg::FREQ_W-1:0] freq,
  output logic                        ready,
  output irfe_pkg::dur_t              dur
);
  import irfe_pkg::*;

  dur_state_t        state_r, state_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [DUR_W-1:0]  dur_r [DUR_COUNT];
  logic              wr_en;
  logic [PROD_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_MUL;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (wr_en) begin
      dur_r[idx_r] <= quot[DUR_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    prod_nxt  = prod_r;
    wr_en     = 1'b0;
    quot      = prod_r >> dur_shift(idx_r);
    case (state_r)
      DS_IDLE: ;
      DS_MUL: begin
        // 17 by 27 bit product with the rounded-up reciprocal of 1e6
        prod_nxt  = PROD_W'(freq) * PROD_W'(dur_recip(idx_r));
        state_nxt = DS_SHIFT;
      end
      DS_SHIFT: begin
        wr_en = 1'b1;
        if (idx_r == 3'(DUR_COUNT - 1)) begin
          state_nxt = DS_IDLE;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = DS_MUL;
        end
      end
      default: state_nxt = DS_IDLE;
    endcase
    if (restart) begin
      state_nxt = DS_MUL;
      idx_nxt   = '0;
    end
  end

  assign ready       = (state_r == DS_IDLE);
  assign dur.half    = dur_r[DUR_HALF];
  assign dur.rc5_gap = dur_r[DUR_RC5_GAP];
  assign dur.nec_hdr = dur_r[DUR_NEC_HDR];
  assign dur.pause   = dur_r[DUR_PAUSE];
  assign dur.short_d = dur_r[DUR_SHORT];
  assign dur.long_d  = dur_r[DUR_LONG];
  assign dur.pd_gap  = dur_r[DUR_PD_GAP];

endmodule

/* rtl/core/irfe_front.sv */
// ----------------------------------------------------------------------------
// irfe_front
// accepts input transfers and turns each into a frame descriptor
// ----------------------------------------------------------------------------
module irfe_front (
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [irfe_pkg::IN_W-1:0] in_tdata,
  input  irfe_pkg::proto_t          proto,
  input  logic                      dur_ready,
  input  logic                      q_full,
  output logic                      q_push,
  output irfe_pkg::desc_t           q_desc
);
  import irfe_pkg::*;

  logic [7:0]  addr;
  logic [7:0]  cmd;
  logic [7:0]  press;
  logic [12:0] word;

  assign addr  = in_tdata[7:0];
  assign cmd   = in_tdata[15:8];
  assign press = in_tdata[23:16];

  assign in_tready = dur_ready && !q_full;
  // an unused protocol code gives no frame at all
  assign q_push    = in_tvalid && in_tready && (proto != PROTO_NONE);

  always_comb begin
    word = {1'b1, press == RC5_TOGGLE_PRESS, addr[4:0], cmd[5:0]};
    q_desc.proto  = proto;
    q_desc.bits   = {~cmd, cmd, ~addr, addr};
    // level slots, mark = 1: a one is space then mark
    q_desc.lvl[0] = 1'b1;
    for (int k = 0; k < 13; k++) begin
      q_desc.lvl[1 + 2*k] = ~word[12 - k];
      q_desc.lvl[2 + 2*k] = word[12 - k];
    end
  end

endmodule

/* rtl/core/irfe_queue.sv */
// ----------------------------------------------------------------------------
// irfe_queue
// two-entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module irfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  irfe_pkg::desc_t wr_desc,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output irfe_pkg::desc_t rd_desc
);
  import irfe_pkg::*;

  desc_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  assign full    = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_desc = mem_r[rd_ptr_r];

endmodule

/* rtl/core/irfe_back.sv */
// ----------------------------------------------------------------------------
// irfe_back
// plays a frame descriptor out as mark/space pairs, one a cycle unless out_tready holds the output
// ----------------------------------------------------------------------------
module irfe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  irfe_pkg::desc_t             q_desc,
  output logic                        q_pop,
  input  irfe_pkg::dur_t              dur,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [irfe_pkg::DUR_W-1:0]  mark,
  output logic [irfe_pkg::DUR_W-1:0]  space,
  output logic                        last
);
  import irfe_pkg::*;

  back_state_t          state_r, state_nxt;
  logic [RC5_SLOTS-1:0] lvl_r, lvl_nxt;
  logic [31:0]          bits_r, bits_nxt;
  logic                 nec_r, nec_nxt;
  logic [4:0]           pos_r, pos_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 ovld_r, ovld_nxt;
  logic [DUR_W-1:0]     mark_r, mark_nxt;
  logic [DUR_W-1:0]     space_r, space_nxt;
  logic                 last_r, last_nxt;

  logic                 out_free;
  logic [31:0]          lvl_ext;
  logic [DUR_W-1:0]     half2;
  logic [4:0]           pos_p1, s, s_p1, np;
  logic                 m2, s_end, s2, np_end;
  logic [DUR_W-1:0]     rc5_mark, rc5_space;
  logic [DUR_W-1:0]     pd_mark, pd_space;
  logic                 pd_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    bits_r  <= bits_nxt;
    nec_r   <= nec_nxt;
    pos_r   <= pos_nxt;
    cnt_r   <= cnt_nxt;
    mark_r  <= mark_nxt;
    space_r <= space_nxt;
    last_r  <= last_nxt;
  end

  // rc5: runs of equal levels merge, at most two half-bits long
  always_comb begin
    lvl_ext = {5'b0, lvl_r};
    half2   = dur.half + dur.half;
    pos_p1  = pos_r + 5'd1;
    m2      = (pos_r < RC5_LAST_SLOT) && lvl_ext[pos_p1];
    s       = pos_p1 + 5'(m2);
    s_end   = (s > RC5_LAST_SLOT);
    s_p1    = s + 5'd1;
    s2      = (s < RC5_LAST_SLOT) && !lvl_ext[s_p1];
    np      = s_p1 + 5'(s2);
    np_end  = (np > RC5_LAST_SLOT);
    rc5_mark = m2 ? half2 : dur.half;
    if (s_end) begin
      rc5_space = dur.rc5_gap;
    end else begin
      rc5_space = (s2 ? half2 : dur.half) + (np_end ? dur.rc5_gap : '0);
    end
  end

  always_comb begin
    pd_last = (cnt_r == PD_LAST_PAIR);
    if (cnt_r == '0) begin
      pd_mark  = nec_r ? dur.nec_hdr : dur.pause;
      pd_space = dur.pause;
    end else if (pd_last) begin
      pd_mark  = dur.short_d;
      pd_space = dur.pd_gap;
    end else begin
      pd_mark  = dur.short_d;
      pd_space = bits_r[0] ? dur.long_d : dur.short_d;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    bits_nxt  = bits_r;
    nec_nxt   = nec_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    mark_nxt  = mark_r;
    space_nxt = space_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    out_free  = !ovld_r || out_tready;
    ovld_nxt  = ovld_r && !out_tready;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          lvl_nxt  = q_desc.lvl;
          bits_nxt = q_desc.bits;
          nec_nxt  = (q_desc.proto == PROTO_NEC);
          pos_nxt  = '0;
          cnt_nxt  = '0;
          state_nxt = (q_desc.proto == PROTO_RC5) ? BK_RC5 : BK_PD;
        end
      end
      BK_RC5: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          mark_nxt  = rc5_mark;
          space_nxt = rc5_space;
          last_nxt  = s_end || np_end;
          pos_nxt   = np;
          if (s_end || np_end) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_PD: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          mark_nxt  = pd_mark;
          space_nxt = pd_space;
          last_nxt  = pd_last;
          cnt_nxt   = cnt_r + 6'd1;
          if (cnt_r != '0) begin
            bits_nxt = {1'b0, bits_r[31:1]};
          end
          if (pd_last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_tvalid = ovld_r;
  assign mark       = mark_r;
  assign space      = space_r;
  assign last       = last_r;

endmodule

/* rtl/core/ir_remote_frame_encoder.sv */
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder
// rc5 / nec / samsung infrared transmit encoder giving mark/space pairs
// ----------------------------------------------------------------------------
// the first pair of a frame goes through the queue, the sequencer state and the output register
// throughput: one pair a cycle unless out_tready holds the output; each frame
//   (rc5 8 to 14 pairs, nec/samsung 34 pairs) also passes the sequencer's idle state
// reset and each carrier_freq write start a duration calculation
//   (7 durations, one multiply plus one shift each); in_tready is low
//   meanwhile. registers reset to carrier_freq 36000 and protocol rc5
// ----------------------------------------------------------------------------
module ir_remote_frame_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [irfe_pkg::IN_W-1:0]     in_tdata,   // addr, cmd, press_number
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [irfe_pkg::OUT_W-1:0]    out_tdata,  // mark_cycles, space_cycles, zero pad
  output logic                          out_tlast,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [irfe_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [irfe_pkg::FREQ_W-1:0]   cfg_wdata
);
  import irfe_pkg::*;

  logic [FREQ_W-1:0] carrier_freq_r;
  proto_t            protocol_r;
  logic              freq_wr;
  logic              dur_ready;
  dur_t              dur;
  logic              q_full, q_push, q_pop, q_valid;
  desc_t             q_wr_desc, q_rd_desc;
  logic [DUR_W-1:0]  mark, space;

  assign freq_wr = cfg_we && (cfg_addr == CFG_CARRIER_FREQ);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_freq_r <= CARRIER_FREQ_RST;
      protocol_r     <= PROTO_RC5;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CARRIER_FREQ: carrier_freq_r <= cfg_wdata;
        CFG_PROTOCOL:     protocol_r     <= proto_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // durations in carrier cycles, recalculated on each frequency change
  irfe_dur u_dur (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (freq_wr),
    .freq    (carrier_freq_r),
    .ready   (dur_ready),
    .dur     (dur)
  );

  // front: takes the transfer and builds the frame descriptor
  irfe_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .proto     (protocol_r),
    .dur_ready (dur_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_wr_desc)
  );

  // decouples acceptance from playout
  irfe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_desc (q_wr_desc),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_desc (q_rd_desc)
  );

  // back: sequences the pairs into the output register
  irfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_rd_desc),
    .q_pop      (q_pop),
    .dur        (dur),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .mark       (mark),
    .space      (space),
    .last       (out_tlast)
  );

  assign out_tdata = {(OUT_W - 2*DUR_W)'(0), space, mark};

endmodule
